// File: rtl/sic_pkg.sv
// Shared constants for the spiral index to grid coordinate block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sic_pkg;

    // Default bit width of the grid side; the spiral index is twice as wide.
    localparam int SIDE_BITS_DEF = 17;

endpackage

`default_nettype wire

// File: rtl/sic_isqrt.sv
// Pipelined integer square root, one root bit resolved per register stage.
// Carries a side tag alongside each value. Depends on sic_pkg.
`default_nettype none

module sic_isqrt #(
    parameter int SB    = sic_pkg::SIDE_BITS_DEF,
    parameter int TAG_W = 3 * sic_pkg::SIDE_BITS_DEF + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ce,
    input  wire logic              in_valid,
    input  wire logic [2*SB+1:0]   rad,
    input  wire logic [TAG_W-1:0]  tag_in,
    output logic                   out_valid,
    output logic [SB:0]            root,
    output logic [SB+3:0]          rem,
    output logic [TAG_W-1:0]       tag_out
);
    import sic_pkg::*;

    localparam int RAD_W  = 2 * SB + 2;
    localparam int ROOT_W = SB + 1;
    localparam int REM_W  = SB + 4;
    localparam int STEPS  = ROOT_W;

    logic              valid_reg [STEPS];
    logic [REM_W-1:0]  rem_reg   [STEPS];
    logic [ROOT_W-1:0] root_reg  [STEPS];
    logic [RAD_W-1:0]  rad_reg   [STEPS];
    logic [TAG_W-1:0]  tag_reg   [STEPS];

    logic              valid_next [STEPS];
    logic [REM_W-1:0]  rem_next   [STEPS];
    logic [ROOT_W-1:0] root_next  [STEPS];
    logic [RAD_W-1:0]  rad_next   [STEPS];
    logic [TAG_W-1:0]  tag_next   [STEPS];

    always_comb
    begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                valid_next[i] = in_valid;
                rem_in        = '0;
                root_in       = '0;
                rad_in        = rad;
                tag_next[i]   = tag_in;
            end
            else
            begin
                valid_next[i] = valid_reg[i-1];
                rem_in        = rem_reg[i-1];
                root_in       = root_reg[i-1];
                rad_in        = rad_reg[i-1];
                tag_next[i]   = tag_reg[i-1];
            end
            // bring down the next two radicand bits and try the new root bit
            cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
            if (cur >= trial)
            begin
                rem_next[i]  = cur - trial;
                root_next[i] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = cur;
                root_next[i] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[i] = {rad_in[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
                tag_reg[i]  <= tag_next[i];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign rem       = rem_reg[STEPS-1];
    assign tag_out   = tag_reg[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/sic_locate.sv
// Ring, leg and coordinate stages: turn the square root into row and column.
// Fed by sic_isqrt; depends on sic_pkg.
`default_nettype none

module sic_locate #(
    parameter int SB    = sic_pkg::SIDE_BITS_DEF,
    parameter int TAG_W = 3 * sic_pkg::SIDE_BITS_DEF + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ce,
    input  wire logic              in_valid,
    input  wire logic [SB:0]       root,
    input  wire logic [SB+3:0]     rem,
    input  wire logic [TAG_W-1:0]  tag,
    output logic                   out_valid,
    output logic [SB-1:0]          row,
    output logic [SB-1:0]          column,
    output logic                   valid_res
);
    import sic_pkg::*;

    localparam int POS_W = 2 * SB;

    // tag layout from the lowest bit: side, position, in-range flag
    logic [SB-1:0]    tag_side;
    logic [POS_W-1:0] tag_pos;
    logic             tag_ok;

    assign tag_side = tag[SB-1:0];
    assign tag_pos  = tag[SB +: POS_W];
    assign tag_ok   = tag[TAG_W-1];

    // ring stage: n = (root-1)/2, registered n*(n+1)
    logic [SB:0]      root_m1;
    logic [SB-1:0]    n_next;
    logic [SB:0]      n_inc;
    logic [POS_W:0]   prod_full;

    assign root_m1   = root - (SB+1)'(1);
    assign n_next    = root_m1[SB:1];
    assign n_inc     = {1'b0, n_next} + (SB+1)'(1);
    assign prod_full = n_next * n_inc;

    logic             r_valid_reg;
    logic             r_ok_reg;
    logic [SB-1:0]    r_n_reg;
    logic [POS_W-1:0] r_prod_reg;
    logic [SB-1:0]    r_side_reg;
    logic [POS_W-1:0] r_pos_reg;

    // leg stage: offset past the ring base, split into leg and turn
    logic [POS_W-1:0] d_full;
    logic [SB+1:0]    d;
    logic [SB:0]      n1;
    logic             past;
    logic [SB+1:0]    over;
    logic [SB-1:0]    leg_next;
    logic [SB-1:0]    turn_next;
    logic [SB-1:0]    half_next;
    logic [SB-1:0]    base_next;

    assign d_full    = r_pos_reg - r_prod_reg - POS_W'(1);
    assign d         = d_full[SB+1:0];
    assign n1        = {1'b0, r_n_reg} + (SB+1)'(1);
    assign past      = d > (SB+2)'(n1);
    assign over      = d - (SB+2)'(n1);
    assign leg_next  = past ? n1[SB-1:0] : d[SB-1:0];
    assign turn_next = past ? over[SB-1:0] : '0;
    assign half_next = n1[SB:1];
    assign base_next = {1'b0, r_side_reg[SB-1:1]} + SB'(1);

    logic             l_valid_reg;
    logic             l_ok_reg;
    logic             l_odd_reg;
    logic [SB-1:0]    l_leg_reg;
    logic [SB-1:0]    l_turn_reg;
    logic [SB-1:0]    l_half_reg;
    logic [SB-1:0]    l_base_reg;

    // coordinate stage, wraps to SB bits
    logic [SB-1:0]    row_next;
    logic [SB-1:0]    column_next;

    always_comb
    begin
        row_next    = '0;
        column_next = '0;
        if (l_ok_reg)
        begin
            if (l_odd_reg)
            begin
                row_next    = l_base_reg + l_half_reg - l_leg_reg;
                column_next = l_base_reg - l_half_reg + l_turn_reg;
            end
            else
            begin
                row_next    = l_base_reg - l_half_reg + l_leg_reg;
                column_next = l_base_reg + l_half_reg - l_turn_reg;
            end
        end
    end

    logic             c_valid_reg;
    logic [SB-1:0]    row_reg;
    logic [SB-1:0]    column_reg;
    logic             valid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            r_valid_reg <= in_valid;
            l_valid_reg <= r_valid_reg;
            c_valid_reg <= l_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_ok_reg      <= tag_ok;
            r_n_reg       <= n_next;
            r_prod_reg    <= prod_full[POS_W-1:0];
            r_side_reg    <= tag_side;
            r_pos_reg     <= tag_pos;

            l_ok_reg      <= r_ok_reg;
            l_odd_reg     <= r_n_reg[0];
            l_leg_reg     <= leg_next;
            l_turn_reg    <= turn_next;
            l_half_reg    <= half_next;
            l_base_reg    <= base_next;

            row_reg       <= row_next;
            column_reg    <= column_next;
            valid_res_reg <= l_ok_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign row       = row_reg;
    assign column    = column_reg;
    assign valid_res = valid_res_reg;

`ifndef SYNTHESIS
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && tag_ok |-> root != '0)
        else $error("zero root for an in-range position");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> rem <= (SB+4)'({root, 1'b0}))
        else $error("square root remainder out of range");

    a_offset_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg && r_ok_reg |-> d_full < POS_W'({n1, 1'b0}))
        else $error("offset past the end of its ring");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && !valid_res_reg |-> row_reg == '0 && column_reg == '0)
        else $error("nonzero coordinates on an invalid result");
`endif

endmodule

`default_nettype wire

// File: rtl/spiral_index_to_grid_coordinate.sv
// Maps a spiral position on a square grid to its 1-based row and column.
// Every beat passes through these pipeline stages in order:
// one front stage forms 4p-3 and side squared, the integer square root resolves one
// root bit per stage over SIDE_BITS+1 stages, and three stages find the ring, the leg
// and the coordinates. A new beat is taken every cycle; when the output beat is not
// taken, the whole pipeline holds and s_axis_tready drops in the same cycle.
// Positions of zero or beyond side squared come out with valid_res low and zero
// coordinates. Depends on sic_pkg, sic_isqrt and sic_locate.
`default_nettype none

module spiral_index_to_grid_coordinate #(
    parameter int SIDE_BITS = sic_pkg::SIDE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // side, position (from bit 0 up), zero padded to bytes
    input  wire logic [((3*SIDE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // row, column (from bit 0 up), zero padded to bytes
    output logic [((2*SIDE_BITS+7)/8)*8-1:0]          m_axis_tdata,
    // valid_res
    output logic [0:0]                                m_axis_tuser
);
    import sic_pkg::*;

    localparam int POS_W = 2 * SIDE_BITS;
    localparam int RAD_W = POS_W + 2;
    localparam int TAG_W = SIDE_BITS + POS_W + 1;
    localparam int OUT_W = ((2*SIDE_BITS+7)/8)*8;

    logic                 ce;
    logic [SIDE_BITS-1:0] side;
    logic [POS_W-1:0]     position;
    logic [RAD_W-1:0]     rad_next;
    logic [POS_W-1:0]     area_next;

    // advance everything unless a finished beat waits at the output
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    assign side      = s_axis_tdata[SIDE_BITS-1:0];
    assign position  = s_axis_tdata[SIDE_BITS +: POS_W];
    assign rad_next  = {position, 2'b00} - RAD_W'(3);
    assign area_next = side * side;

    logic                 f_valid_reg;
    logic [SIDE_BITS-1:0] f_side_reg;
    logic [POS_W-1:0]     f_pos_reg;
    logic [RAD_W-1:0]     f_rad_reg;
    logic [POS_W-1:0]     f_area_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            f_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f_side_reg <= side;
            f_pos_reg  <= position;
            f_rad_reg  <= rad_next;
            f_area_reg <= area_next;
        end
    end

    logic             in_range;
    logic [TAG_W-1:0] tag_in;

    assign in_range = (f_pos_reg != '0) && (f_pos_reg <= f_area_reg);
    assign tag_in   = {in_range, f_pos_reg, f_side_reg};

    logic                 sq_valid;
    logic [SIDE_BITS:0]   sq_root;
    logic [SIDE_BITS+3:0] sq_rem;
    logic [TAG_W-1:0]     sq_tag;

    sic_isqrt #(
        .SB    (SIDE_BITS),
        .TAG_W (TAG_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (f_valid_reg),
        .rad       (f_rad_reg),
        .tag_in    (tag_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .rem       (sq_rem),
        .tag_out   (sq_tag)
    );

    logic [SIDE_BITS-1:0] row;
    logic [SIDE_BITS-1:0] column;
    logic                 valid_res;

    sic_locate #(
        .SB    (SIDE_BITS),
        .TAG_W (TAG_W)
    ) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .rem       (sq_rem),
        .tag       (sq_tag),
        .out_valid (m_axis_tvalid),
        .row       (row),
        .column    (column),
        .valid_res (valid_res)
    );

    assign m_axis_tdata    = OUT_W'({column, row});
    assign m_axis_tuser[0] = valid_res;

endmodule

`default_nettype wire
